// File: hw/rtl/tskf_pkg.sv
// Shared types and constants for the two-sensor scalar Kalman fusion block.
// No dependencies; imported by the interfaces and the top level.
package tskf_pkg;

   // Sample width (signed Q8.8 at 16 bits)
   localparam int SAMPLE_BITS = 16;

   // Error registers are unsigned Q4.12
   localparam int REG_BITS = 16;
   localparam logic [REG_BITS-1:0] INIT_ERR_RESET = 16'd3236;
   localparam logic [REG_BITS-1:0] MEAS_ERR_RESET = 16'd3768;

   // Gain is Q0.16 but needs a 17th bit to hold exactly 1.0
   localparam int FRAC_BITS = 16;
   localparam int GAIN_BITS = FRAC_BITS + 1;
   localparam int DEN_BITS  = REG_BITS + 1;
   localparam int REM_BITS  = DEN_BITS + 1;
   localparam int DIV_STEPS = GAIN_BITS;
   localparam int CNT_BITS  = $clog2(DIV_STEPS);

   // Shared multiplier: operand A is the sample difference or (1 - K),
   // operand B is K or P, both signed
   localparam int DIFF_BITS  = SAMPLE_BITS + 1;
   localparam int MUL_A_BITS = (DIFF_BITS > GAIN_BITS + 1) ? DIFF_BITS : GAIN_BITS + 1;
   localparam int MUL_B_BITS = GAIN_BITS + 1;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_ERROR     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MEASUREMENT_ERROR = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL_FUSE,
      ST_MUL_ERR,
      ST_UPDATE,
      ST_OUT
   } state_type;

endpackage

// File: hw/rtl/tskf_intf.sv
// Valid/ready channel interfaces for the fusion block: request and response.
// Depends on tskf_pkg.
interface tskf_req_if
   import tskf_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_a;
   logic signed [SAMPLE_BITS-1:0] sample_b;
   logic                          first_of_run;

   modport source (output valid, sample_a, sample_b, first_of_run, input ready);
   modport sink   (input valid, sample_a, sample_b, first_of_run, output ready);
endinterface

interface tskf_rsp_if
   import tskf_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] fused;

   modport source (output valid, fused, input ready);
   modport sink   (input valid, fused, output ready);
endinterface

// File: hw/rtl/two_sensor_scalar_kalman_fusion_top.sv
// Top level of the two-sensor scalar Kalman fusion block.
// Depends on tskf_pkg and the channel interfaces in tskf_intf.sv.

// Each request carries readings A and B (B is the prior) and a first_of_run
// flag that reloads the estimate error P from initial_error. The gain
// K = P/(P+R) comes from a restoring divider that produces one quotient bit
// per cycle; one shared 18-bit signed multiplier then forms (A-B)*K and
// (1-K)*P in turn, and a final update state commits the new P. The block
// accepts no new request until the response is taken and is ready again in
// the cycle after that. Write the csr registers only while the block is idle.
module two_sensor_scalar_kalman_fusion_top
   import tskf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   tskf_req_if.sink                  req,
   tskf_rsp_if.source                rsp,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [REG_BITS-1:0]       csr_wdata
);

   state_type state_ff, state_in;

   logic [REG_BITS-1:0]  init_err_ff,  init_err_in;
   logic [REG_BITS-1:0]  meas_err_ff,  meas_err_in;
   logic [REG_BITS-1:0]  p_ff,         p_in;
   logic signed [SAMPLE_BITS-1:0] a_ff, a_in;
   logic signed [SAMPLE_BITS-1:0] b_ff, b_in;
   logic [DEN_BITS-1:0]  den_ff,       den_in;
   logic [REM_BITS-1:0]  rem_ff,       rem_in;
   logic [GAIN_BITS-1:0] quo_ff,       quo_in;
   logic [CNT_BITS-1:0]  cnt_ff,       cnt_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [SAMPLE_BITS-1:0] fused_ff, fused_in;

   // control from the sequencer
   logic req_take;
   logic div_step;
   logic mul_fuse;
   logic mul_err;
   logic do_update;
   logic rsp_done;

   // datapath intermediates
   logic [REG_BITS-1:0]   p_start;
   logic [REM_BITS-1:0]   den_ext;
   logic                  rem_ge;
   logic [REM_BITS-1:0]   rem_sel;
   logic [GAIN_BITS-1:0]  gain;
   logic [GAIN_BITS-1:0]  one_minus_gain;
   logic signed [DIFF_BITS-1:0]  diff;
   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0]  mul_p;
   logic signed [PROD_BITS-1:0]  prod_rnd;
   logic signed [PROD_BITS-1:0]  prod_shr;

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == '0) state_in = ST_MUL_FUSE;
         end
         ST_MUL_FUSE: state_in = ST_MUL_ERR;
         ST_MUL_ERR:  state_in = ST_UPDATE;
         ST_UPDATE:   state_in = ST_OUT;
         ST_OUT: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      div_step  = 1'b0;
      mul_fuse  = 1'b0;
      mul_err   = 1'b0;
      do_update = 1'b0;
      unique case (state_ff)
         ST_IDLE:     req.ready = 1'b1;
         ST_DIV:      div_step  = 1'b1;
         ST_MUL_FUSE: mul_fuse  = 1'b1;
         ST_MUL_ERR:  mul_err   = 1'b1;
         ST_UPDATE:   do_update = 1'b1;
         ST_OUT:      rsp.valid = 1'b1;
         default: begin
         end
      endcase
   end

   assign req_take  = req.valid && req.ready;
   assign rsp_done  = rsp.valid && rsp.ready;
   assign rsp.fused = fused_ff;

   // ---------------- datapath ----------------
   assign p_start = req.first_of_run ? init_err_ff : p_ff;

   // restoring divider, one quotient bit per cycle
   assign den_ext = {1'b0, den_ff};
   assign rem_ge  = (rem_ff >= den_ext);
   assign rem_sel = rem_ge ? (rem_ff - den_ext) : rem_ff;

   // zero denominator gives zero gain
   assign gain           = (den_ff == '0) ? '0 : quo_ff;
   assign one_minus_gain = GAIN_BITS'(1 << FRAC_BITS) - gain;
   assign diff           = DIFF_BITS'(a_ff) - DIFF_BITS'(b_ff);

   // shared multiplier operand select
   always_comb begin
      if (mul_err) begin
         mul_a = MUL_A_BITS'({1'b0, one_minus_gain});
         mul_b = MUL_B_BITS'({1'b0, p_ff});
      end else begin
         mul_a = MUL_A_BITS'(diff);
         mul_b = MUL_B_BITS'({1'b0, gain});
      end
   end

   assign mul_p    = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   // round to nearest, ties up, then drop the gain fraction
   assign prod_rnd = prod_ff + PROD_BITS'(1 << (FRAC_BITS - 1));
   assign prod_shr = prod_rnd >>> FRAC_BITS;

   always_comb begin
      init_err_in = init_err_ff;
      meas_err_in = meas_err_ff;
      p_in        = p_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      den_in      = den_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      cnt_in      = cnt_ff;
      prod_in     = prod_ff;
      fused_in    = fused_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INITIAL_ERROR:     init_err_in = csr_wdata;
            CSR_MEASUREMENT_ERROR: meas_err_in = csr_wdata;
            default: begin
            end
         endcase
      end

      if (req_take) begin
         a_in   = req.sample_a;
         b_in   = req.sample_b;
         p_in   = p_start;
         den_in = DEN_BITS'(p_start) + DEN_BITS'(meas_err_ff);
         rem_in = REM_BITS'(p_start);
         quo_in = '0;
         cnt_in = CNT_BITS'(DIV_STEPS - 1);
      end

      if (div_step) begin
         quo_in = {quo_ff[GAIN_BITS-2:0], rem_ge};
         rem_in = {rem_sel[REM_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end

      if (mul_fuse) begin
         prod_in = mul_p;
      end

      if (mul_err) begin
         fused_in = b_ff + prod_shr[SAMPLE_BITS-1:0];
         prod_in  = mul_p;
      end

      if (do_update) begin
         p_in = prod_shr[REG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         init_err_ff <= INIT_ERR_RESET;
         meas_err_ff <= MEAS_ERR_RESET;
         p_ff        <= INIT_ERR_RESET;
      end else begin
         state_ff    <= state_in;
         init_err_ff <= init_err_in;
         meas_err_ff <= meas_err_in;
         p_ff        <= p_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      fused_ff <= rsp_done ? fused_ff : fused_in;
   end

endmodule
